### rtl/pjss_pkg.sv
// Shared widths, command codes and control structs of the pairwise job-shop scheduler.
package pjss_pkg;

    localparam int OP_W   = 3;
    localparam int MACH_W = 8;
    localparam int DUR_W  = 32;
    localparam int ID_W   = 12;
    localparam int TIME_W = 48;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OP_W-1:0] OP_SCHED  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd4;

    localparam logic [STAT_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REPORT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [MACH_W-1:0] mach;
        logic [DUR_W-1:0]  dur;
    } step_t;

    localparam int STEP_W = MACH_W + DUR_W;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic emit_drop;
        logic emit_report;
        logic sched_init;
        logic clr_init;
        logic clr_step;
        logic decide;
        logic sel_b;
        logic adv_a;
        logic adv_b;
        logic calc_max;
        logic calc_add;
        logic emit_place;
        logic last;
        logic next_a;
        logic end_sched;
    } cmd_t;

    typedef struct packed {
        logic a_left;
        logic b_left;
        logic same_mach;
        logic a_longer;
        logic full_a;
        logic full_b;
        logic clr_done;
    } status_t;

endpackage

### rtl/pjss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pjss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/pjss_datapath.sv
// Datapath: step buffers, machine free-time memory, placement arithmetic and result registers.
module pjss_datapath #(
    parameter int MAX_MACHINES = 256,
    parameter int MAX_STEPS    = 32,
    parameter int JOB_ID_WIDTH = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pjss_pkg::cmd_t                    cmd,
    output pjss_pkg::status_t                 st,
    input  logic [pjss_pkg::MACH_W-1:0]       machine,
    input  logic [pjss_pkg::DUR_W-1:0]        duration,
    input  logic [pjss_pkg::ID_W-1:0]         job_a_id,
    input  logic [pjss_pkg::ID_W-1:0]         job_b_id,
    output logic                              strobe,
    output logic [pjss_pkg::ID_W-1:0]         job_id,
    output logic [pjss_pkg::MACH_W-1:0]       machine_used,
    output logic [pjss_pkg::TIME_W-1:0]       start_time,
    output logic [pjss_pkg::TIME_W-1:0]       finish_time,
    output logic [pjss_pkg::TIME_W-1:0]       makespan,
    output logic [pjss_pkg::STAT_W-1:0]       status,
    output logic                              last
);

    localparam int MW       = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int SW       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW       = $clog2(MAX_STEPS + 1);
    localparam int MachVals = 2 ** pjss_pkg::MACH_W;
    localparam int TW       = pjss_pkg::TIME_W;
    localparam logic [pjss_pkg::ID_W-1:0] IdMask = pjss_pkg::ID_W'((1 << JOB_ID_WIDTH) - 1);

    logic [CW-1:0]            cnt_a_reg, cnt_b_reg, ia_reg, ib_reg;
    logic [pjss_pkg::ID_W-1:0] ida_reg, idb_reg;
    logic [TW-1:0]            ta_reg, tb_reg, start_reg, fin_reg, mksp_reg;
    logic [TW-1:0]            fin_next, mksp_next, ready, mt_q;
    logic [TW:0]              sum;
    logic                     sel_b_reg;
    logic [MW-1:0]            midx, midx_reg, clr_cnt_reg;
    logic [MW-1:0]            mod_tab [MachVals];
    pjss_pkg::step_t          hold_a_reg, hold_b_reg, cur, step_a_q, step_b_q, load_step;
    logic                     mt_we;
    logic [MW-1:0]            mt_waddr;
    logic [TW-1:0]            mt_wdata;

    // Machine index reduction, folded into a constant table over all stored machine codes.
    genvar g;
    for (g = 0; g < MachVals; g++)
    begin : g_mod
        assign mod_tab[g] = MW'(g % MAX_MACHINES);
    end

    assign load_step = '{mach: machine, dur: duration};

    pjss_ram #(.WIDTH(pjss_pkg::STEP_W), .DEPTH(MAX_STEPS)) u_steps_a (
        .clk   (clk),
        .we    (cmd.load_a),
        .waddr (cnt_a_reg[SW-1:0]),
        .wdata (load_step),
        .raddr (ia_reg[SW-1:0]),
        .rdata (step_a_q)
    );

    pjss_ram #(.WIDTH(pjss_pkg::STEP_W), .DEPTH(MAX_STEPS)) u_steps_b (
        .clk   (clk),
        .we    (cmd.load_b),
        .waddr (cnt_b_reg[SW-1:0]),
        .wdata (load_step),
        .raddr (ib_reg[SW-1:0]),
        .rdata (step_b_q)
    );

    assign cur  = sel_b_reg ? hold_b_reg : hold_a_reg;
    assign midx = mod_tab[cur.mach];

    assign mt_we    = cmd.clr_step | cmd.calc_add;
    assign mt_waddr = cmd.clr_step ? clr_cnt_reg : midx_reg;
    assign mt_wdata = cmd.clr_step ? '0 : fin_next;

    pjss_ram #(.WIDTH(TW), .DEPTH(MAX_MACHINES)) u_free_time (
        .clk   (clk),
        .we    (mt_we),
        .waddr (mt_waddr),
        .wdata (mt_wdata),
        .raddr (midx),
        .rdata (mt_q)
    );

    assign ready     = sel_b_reg ? tb_reg : ta_reg;
    assign sum       = {1'b0, start_reg} + (TW + 1)'(cur.dur);
    assign fin_next  = sum[TW] ? pjss_pkg::TIME_MAX : sum[TW-1:0];
    assign mksp_next = (fin_reg > mksp_reg) ? fin_reg : mksp_reg;

    assign st.a_left    = ia_reg < cnt_a_reg;
    assign st.b_left    = ib_reg < cnt_b_reg;
    assign st.same_mach = step_a_q.mach == step_b_q.mach;
    assign st.a_longer  = step_a_q.dur > step_b_q.dur;
    assign st.full_a    = cnt_a_reg == CW'(MAX_STEPS);
    assign st.full_b    = cnt_b_reg == CW'(MAX_STEPS);
    assign st.clr_done  = clr_cnt_reg == MW'(MAX_MACHINES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            clr_cnt_reg <= '0;
            mksp_reg    <= '0;
            strobe      <= 1'b0;
        end
        else
        begin
            strobe <= cmd.emit_place | cmd.emit_drop | cmd.emit_report;
            if (cmd.load_a)
            begin
                cnt_a_reg <= cnt_a_reg + 1'b1;
            end
            if (cmd.load_b)
            begin
                cnt_b_reg <= cnt_b_reg + 1'b1;
            end
            if (cmd.end_sched)
            begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
            end
            if (cmd.sched_init)
            begin
                ia_reg <= '0;
                ib_reg <= '0;
            end
            if (cmd.decide && cmd.adv_a)
            begin
                ia_reg <= ia_reg + 1'b1;
            end
            if (cmd.decide && cmd.adv_b)
            begin
                ib_reg <= ib_reg + 1'b1;
            end
            if (cmd.clr_init)
            begin
                clr_cnt_reg <= '0;
                mksp_reg    <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.emit_place)
            begin
                mksp_reg <= mksp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sched_init)
        begin
            ida_reg <= job_a_id & IdMask;
            idb_reg <= job_b_id & IdMask;
            ta_reg  <= '0;
            tb_reg  <= '0;
        end
        if (cmd.decide)
        begin
            hold_a_reg <= step_a_q;
            hold_b_reg <= step_b_q;
            sel_b_reg  <= cmd.sel_b;
        end
        if (cmd.next_a)
        begin
            sel_b_reg <= 1'b0;
        end
        if (cmd.calc_max)
        begin
            start_reg <= (mt_q > ready) ? mt_q : ready;
            midx_reg  <= midx;
        end
        if (cmd.calc_add)
        begin
            fin_reg <= fin_next;
            if (sel_b_reg)
            begin
                tb_reg <= fin_next;
            end
            else
            begin
                ta_reg <= fin_next;
            end
        end
        if (cmd.emit_place)
        begin
            job_id       <= sel_b_reg ? idb_reg : ida_reg;
            machine_used <= cur.mach;
            start_time   <= start_reg;
            finish_time  <= fin_reg;
            makespan     <= mksp_next;
            status       <= pjss_pkg::ST_PLACED;
            last         <= cmd.last;
        end
        else if (cmd.emit_drop || cmd.emit_report)
        begin
            job_id       <= '0;
            machine_used <= '0;
            start_time   <= '0;
            finish_time  <= '0;
            makespan     <= mksp_reg;
            status       <= cmd.emit_drop ? pjss_pkg::ST_DROPPED : pjss_pkg::ST_REPORT;
            last         <= 1'b1;
        end
    end

    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CW'(MAX_STEPS)) && (cnt_b_reg <= CW'(MAX_STEPS)))
        else $error("step count beyond buffer depth");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> (ia_reg <= cnt_a_reg) && (ib_reg <= cnt_b_reg))
        else $error("step walk ran past the loaded steps");

endmodule

### rtl/pjss_ctrl.sv
// Controller: command decode and the sequencer that walks a job pair.
module pjss_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pjss_pkg::OP_W-1:0]   opcode,
    input  pjss_pkg::status_t           st,
    output logic                        busy,
    output pjss_pkg::cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_FETCH,
        S_DECIDE,
        S_RD,
        S_MAX,
        S_ADD,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   busy_reg;
    logic   accept;

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        pjss_pkg::OP_LOAD_A:
                        begin
                            cmd.emit_drop = st.full_a;
                            cmd.load_a    = !st.full_a;
                        end
                        pjss_pkg::OP_LOAD_B:
                        begin
                            cmd.emit_drop = st.full_b;
                            cmd.load_b    = !st.full_b;
                        end
                        pjss_pkg::OP_SCHED:
                        begin
                            cmd.sched_init = 1'b1;
                            state_next     = S_FETCH;
                        end
                        pjss_pkg::OP_CLEAR:
                        begin
                            cmd.clr_init = 1'b1;
                            state_next   = S_CLR;
                        end
                        pjss_pkg::OP_REPORT:
                        begin
                            cmd.emit_report = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (!st.a_left && !st.b_left)
                begin
                    cmd.end_sched = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_RD;
                if (!st.b_left)
                begin
                    cmd.adv_a = 1'b1;
                end
                else if (!st.a_left)
                begin
                    cmd.sel_b = 1'b1;
                    cmd.adv_b = 1'b1;
                end
                else if (!st.same_mach)
                begin
                    // Both are placed, B's step first and A's after it.
                    cmd.sel_b = 1'b1;
                    cmd.adv_a = 1'b1;
                    cmd.adv_b = 1'b1;
                    pend_next = 1'b1;
                end
                else if (st.a_longer)
                begin
                    cmd.adv_a = 1'b1;
                end
                else
                begin
                    cmd.sel_b = 1'b1;
                    cmd.adv_b = 1'b1;
                end
            end
            S_RD:
            begin
                state_next = S_MAX;
            end
            S_MAX:
            begin
                cmd.calc_max = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.calc_add = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_place = 1'b1;
                cmd.last       = !pend_reg && !st.a_left && !st.b_left;
                if (pend_reg)
                begin
                    cmd.next_a = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_RD;
                end
                else if (!st.a_left && !st.b_left)
                begin
                    cmd.end_sched = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            pend_reg  <= 1'b0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            busy_reg  <= state_next != S_IDLE;
        end
    end

    a_decide_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (st.a_left || st.b_left))
        else $error("placement decision with both jobs exhausted");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_place && cmd.last) |=> (state_reg == S_IDLE) && !busy_reg)
        else $error("final placement did not end the schedule");

endmodule

### rtl/pairwise_job_shop_scheduler.sv
// Top level of the pairwise job-shop scheduler: controller, datapath and port wiring.
//
// Items enter on start when busy is low; opcode selects the command, machine and
// duration go with loads, job_a_id and job_b_id with a schedule command.
// Results leave on strobe, one cycle each, and the receiver cannot stall them.
// Loads keep busy low, so they may follow back to back; a load into a full step
// buffer gives a dropped result on strobe in the next cycle.
// A report gives its result in the next cycle and keeps busy low.
// A schedule command first fetches the first steps, then decides each round and
// passes each placed operation through free-time read, start compare, finish add
// and write-back, and result register. This order is set by the read-modify-write
// of the machine free-time memory. Each result appears on strobe in the cycle after
// its register cycle; busy falls with the final one.
// A clear command, and reset likewise, run a clearing pass over all MAX_MACHINES
// entries of the free-time memory, one entry a cycle, with busy high throughout.
module pairwise_job_shop_scheduler #(
    parameter int MAX_MACHINES = 256,
    parameter int MAX_STEPS    = 32,
    parameter int JOB_ID_WIDTH = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pjss_pkg::OP_W-1:0]         opcode,
    input  logic [pjss_pkg::MACH_W-1:0]       machine,
    input  logic [pjss_pkg::DUR_W-1:0]        duration,
    input  logic [pjss_pkg::ID_W-1:0]         job_a_id,
    input  logic [pjss_pkg::ID_W-1:0]         job_b_id,
    output logic                              strobe,
    output logic [pjss_pkg::ID_W-1:0]         job_id,
    output logic [pjss_pkg::MACH_W-1:0]       machine_used,
    output logic [pjss_pkg::TIME_W-1:0]       start_time,
    output logic [pjss_pkg::TIME_W-1:0]       finish_time,
    output logic [pjss_pkg::TIME_W-1:0]       makespan,
    output logic [pjss_pkg::STAT_W-1:0]       status,
    output logic                              last
);

    pjss_pkg::cmd_t    cmd;
    pjss_pkg::status_t st;

    pjss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .st     (st),
        .busy   (busy),
        .cmd    (cmd)
    );

    pjss_datapath #(
        .MAX_MACHINES (MAX_MACHINES),
        .MAX_STEPS    (MAX_STEPS),
        .JOB_ID_WIDTH (JOB_ID_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .machine      (machine),
        .duration     (duration),
        .job_a_id     (job_a_id),
        .job_b_id     (job_b_id),
        .strobe       (strobe),
        .job_id       (job_id),
        .machine_used (machine_used),
        .start_time   (start_time),
        .finish_time  (finish_time),
        .makespan     (makespan),
        .status       (status),
        .last         (last)
    );

endmodule

### test/tb_pairwise_job_shop_scheduler.sv
// Self-checking testbench for the pairwise job-shop scheduler with its own schedule predictor.
`timescale 1ns / 100ps

module tb_pairwise_job_shop_scheduler;

    localparam int N_MACH      = 256;
    localparam int N_STEPS     = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 300;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 80;

    localparam logic [pjss_pkg::OP_W-1:0]  OP_SPARE = 3'd5;
    localparam logic [pjss_pkg::DUR_W-1:0] DUR_MAX  = '1;
    localparam logic [pjss_pkg::ID_W-1:0]  ID_MAX   = '1;

    typedef struct packed {
        logic [pjss_pkg::ID_W-1:0]   job_id;
        logic [pjss_pkg::MACH_W-1:0] machine_used;
        logic [pjss_pkg::TIME_W-1:0] start_time;
        logic [pjss_pkg::TIME_W-1:0] finish_time;
        logic [pjss_pkg::TIME_W-1:0] makespan;
        logic [pjss_pkg::STAT_W-1:0] status;
        logic                        last;
    } result_t;

    class schedule_scoreboard;
        logic [pjss_pkg::TIME_W-1:0] free_at [N_MACH];
        logic [pjss_pkg::MACH_W-1:0] a_mach [N_STEPS];
        logic [pjss_pkg::DUR_W-1:0]  a_dur [N_STEPS];
        logic [pjss_pkg::MACH_W-1:0] b_mach [N_STEPS];
        logic [pjss_pkg::DUR_W-1:0]  b_dur [N_STEPS];
        int                          a_cnt;
        int                          b_cnt;
        logic [pjss_pkg::TIME_W-1:0] span;
        result_t                     expected_q [$];
        int                          mismatches;

        function new();
            foreach (free_at[i])
                free_at[i] = '0;
            a_cnt      = 0;
            b_cnt      = 0;
            span       = '0;
            mismatches = 0;
        endfunction

        function void push_result(logic [pjss_pkg::ID_W-1:0] id,
                                  logic [pjss_pkg::MACH_W-1:0] m,
                                  logic [pjss_pkg::TIME_W-1:0] st,
                                  logic [pjss_pkg::TIME_W-1:0] fin,
                                  logic [pjss_pkg::STAT_W-1:0] stat, logic fin_flag);
            result_t r;
            r.job_id       = id;
            r.machine_used = m;
            r.start_time   = st;
            r.finish_time  = fin;
            r.makespan     = span;
            r.status       = stat;
            r.last         = fin_flag;
            expected_q.push_back(r);
        endfunction

        function void place_step(input logic [pjss_pkg::MACH_W-1:0] m,
                                 input logic [pjss_pkg::DUR_W-1:0] d,
                                 inout logic [pjss_pkg::TIME_W-1:0] ready,
                                 input logic [pjss_pkg::ID_W-1:0] id);
            logic [pjss_pkg::TIME_W:0]   sum;
            logic [pjss_pkg::TIME_W-1:0] st;
            logic [pjss_pkg::TIME_W-1:0] fin;
            st = free_at[m];
            if (ready > st)
                st = ready;
            sum = {1'b0, st} + (pjss_pkg::TIME_W + 1)'(d);
            fin = sum[pjss_pkg::TIME_W] ? pjss_pkg::TIME_MAX : sum[pjss_pkg::TIME_W-1:0];
            free_at[m] = fin;
            ready      = fin;
            if (fin > span)
                span = fin;
            push_result(id, m, st, fin, pjss_pkg::ST_PLACED, 1'b0);
        endfunction

        function void schedule_pair(logic [pjss_pkg::ID_W-1:0] ida,
                                    logic [pjss_pkg::ID_W-1:0] idb);
            int                          ia;
            int                          ib;
            int                          n0;
            logic [pjss_pkg::TIME_W-1:0] ta;
            logic [pjss_pkg::TIME_W-1:0] tb;
            result_t                     r;
            ia = 0;
            ib = 0;
            ta = '0;
            tb = '0;
            n0 = expected_q.size();
            while (ia < a_cnt || ib < b_cnt)
            begin
                if (ia >= a_cnt)
                begin
                    place_step(b_mach[ib], b_dur[ib], tb, idb);
                    ib++;
                end
                else if (ib >= b_cnt)
                begin
                    place_step(a_mach[ia], a_dur[ia], ta, ida);
                    ia++;
                end
                else if (a_mach[ia] != b_mach[ib])
                begin
                    // Both go in one round, job B's result ahead of job A's.
                    place_step(b_mach[ib], b_dur[ib], tb, idb);
                    place_step(a_mach[ia], a_dur[ia], ta, ida);
                    ia++;
                    ib++;
                end
                else if (a_dur[ia] > b_dur[ib])
                begin
                    place_step(a_mach[ia], a_dur[ia], ta, ida);
                    ia++;
                end
                else
                begin
                    place_step(b_mach[ib], b_dur[ib], tb, idb);
                    ib++;
                end
            end
            a_cnt = 0;
            b_cnt = 0;
            if (expected_q.size() > n0)
            begin
                r = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void note_command(logic [pjss_pkg::OP_W-1:0] op,
                                   logic [pjss_pkg::MACH_W-1:0] m,
                                   logic [pjss_pkg::DUR_W-1:0] d,
                                   logic [pjss_pkg::ID_W-1:0] ida,
                                   logic [pjss_pkg::ID_W-1:0] idb);
            case (op)
                pjss_pkg::OP_LOAD_A:
                begin
                    if (a_cnt >= N_STEPS)
                        push_result('0, '0, '0, '0, pjss_pkg::ST_DROPPED, 1'b1);
                    else
                    begin
                        a_mach[a_cnt] = m;
                        a_dur[a_cnt]  = d;
                        a_cnt++;
                    end
                end
                pjss_pkg::OP_LOAD_B:
                begin
                    if (b_cnt >= N_STEPS)
                        push_result('0, '0, '0, '0, pjss_pkg::ST_DROPPED, 1'b1);
                    else
                    begin
                        b_mach[b_cnt] = m;
                        b_dur[b_cnt]  = d;
                        b_cnt++;
                    end
                end
                pjss_pkg::OP_SCHED:
                    schedule_pair(ida, idb);
                pjss_pkg::OP_CLEAR:
                begin
                    foreach (free_at[i])
                        free_at[i] = '0;
                    span = '0;
                end
                pjss_pkg::OP_REPORT:
                    push_result('0, '0, '0, '0, pjss_pkg::ST_REPORT, 1'b1);
                default:
                    ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: job %0d machine %0d status %0d",
                             got.job_id, got.machine_used, got.status);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch (expected / actual) at %0t:", $time);
                        $display("  job_id %0d / %0d  machine_used %0d / %0d",
                                 want.job_id, got.job_id,
                                 want.machine_used, got.machine_used);
                        $display("  start_time %0d / %0d  finish_time %0d / %0d",
                                 want.start_time, got.start_time,
                                 want.finish_time, got.finish_time);
                        $display("  makespan %0d / %0d  status %0d / %0d  last %0d / %0d",
                                 want.makespan, got.makespan, want.status, got.status,
                                 want.last, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [pjss_pkg::OP_W-1:0]   opcode = '0;
    logic [pjss_pkg::MACH_W-1:0] machine = '0;
    logic [pjss_pkg::DUR_W-1:0]  duration = '0;
    logic [pjss_pkg::ID_W-1:0]   job_a_id = '0;
    logic [pjss_pkg::ID_W-1:0]   job_b_id = '0;
    logic                        busy;
    logic                        strobe;
    logic [pjss_pkg::ID_W-1:0]   job_id;
    logic [pjss_pkg::MACH_W-1:0] machine_used;
    logic [pjss_pkg::TIME_W-1:0] start_time;
    logic [pjss_pkg::TIME_W-1:0] finish_time;
    logic [pjss_pkg::TIME_W-1:0] makespan;
    logic [pjss_pkg::STAT_W-1:0] status;
    logic                        last;

    schedule_scoreboard sb;
    int                 quiet_cycles = 0;

    pairwise_job_shop_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .machine      (machine),
        .duration     (duration),
        .job_a_id     (job_a_id),
        .job_b_id     (job_b_id),
        .strobe       (strobe),
        .job_id       (job_id),
        .machine_used (machine_used),
        .start_time   (start_time),
        .finish_time  (finish_time),
        .makespan     (makespan),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Monitor and watchdog: everything is sampled at the rising edge, before the
    // block's own updates for that edge land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_result({job_id, machine_used, start_time, finish_time,
                                 makespan, status, last});
            if (start && !busy)
                sb.note_command(opcode, machine, duration, job_a_id, job_b_id);
            if ((start && !busy) || strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic issue(logic [pjss_pkg::OP_W-1:0] op, logic [pjss_pkg::MACH_W-1:0] m,
                         logic [pjss_pkg::DUR_W-1:0] d, logic [pjss_pkg::ID_W-1:0] ida,
                         logic [pjss_pkg::ID_W-1:0] idb);
        opcode   <= op;
        machine  <= m;
        duration <= d;
        job_a_id <= ida;
        job_b_id <= idb;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [pjss_pkg::MACH_W-1:0] rnd_mach();
        return pjss_pkg::MACH_W'($urandom);
    endfunction

    function automatic logic [pjss_pkg::ID_W-1:0] rnd_id();
        return pjss_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [pjss_pkg::DUR_W-1:0] pick_dur();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DUR_MAX;
            2, 3, 4: return $urandom;
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic int pick_len();
        int x;
        x = $urandom_range(0, 99);
        if (x < 8)
            return 0;
        else if (x < 88)
            return $urandom_range(1, 6);
        else if (x < 95)
            return $urandom_range(7, N_STEPS);
        else
            return $urandom_range(N_STEPS + 1, N_STEPS + 3);
    endfunction

    // One pair: loads for both jobs interleaved at random, then the schedule.
    task automatic run_pair(int na, int nb, int pct, inout int items);
        int   la;
        int   lb;
        logic narrow;
        logic to_b;
        la     = 0;
        lb     = 0;
        narrow = ($urandom_range(0, 99) < 60);
        while (la < na || lb < nb)
        begin
            to_b = (la >= na) || (lb < nb && $urandom_range(0, 1) == 1);
            issue(to_b ? pjss_pkg::OP_LOAD_B : pjss_pkg::OP_LOAD_A,
                  narrow ? pjss_pkg::MACH_W'($urandom_range(0, 3)) : rnd_mach(),
                  pick_dur(), rnd_id(), rnd_id());
            if (to_b)
                lb++;
            else
                la++;
            items++;
            pause(pct);
        end
        issue(pjss_pkg::OP_SCHED, rnd_mach(), $urandom, rnd_id(), rnd_id());
        items++;
        pause(pct);
    endtask

    task automatic run_phase(int pct, int quota, logic fill_first);
        int items;
        int r;
        items = 0;
        if (fill_first)
            run_pair(N_STEPS + 2, N_STEPS + 2, pct, items);
        while (items < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                issue(pjss_pkg::OP_REPORT, rnd_mach(), $urandom, rnd_id(), rnd_id());
                items++;
                pause(pct);
            end
            else if (r < 9)
            begin
                issue(pjss_pkg::OP_CLEAR, rnd_mach(), $urandom, rnd_id(), rnd_id());
                items++;
                pause(pct);
            end
            else if (r < 12)
            begin
                // Spare opcodes are ignored and not counted.
                issue(pjss_pkg::OP_W'(OP_SPARE + $urandom_range(0, 2)), rnd_mach(),
                      $urandom, rnd_id(), rnd_id());
                pause(pct);
            end
            else
                run_pair(pick_len(), pick_len(), pct, items);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(pjss_pkg::OP_REPORT, '0, '0, '0, '0);
        // Different machines with extreme field values.
        issue(pjss_pkg::OP_LOAD_A, '0, '0, '0, '0);
        issue(pjss_pkg::OP_LOAD_B, 8'd255, DUR_MAX, ID_MAX, ID_MAX);
        issue(pjss_pkg::OP_SCHED, 8'd255, DUR_MAX, '0, ID_MAX);
        // Same machine, equal durations: job B goes first.
        issue(pjss_pkg::OP_LOAD_A, 8'd5, 32'd10, '0, '0);
        issue(pjss_pkg::OP_LOAD_B, 8'd5, 32'd10, '0, '0);
        issue(pjss_pkg::OP_SCHED, '0, '0, 12'd1, 12'd2);
        // Same machine, job A longer: job A goes first.
        issue(pjss_pkg::OP_LOAD_A, 8'd7, 32'd20, '0, '0);
        issue(pjss_pkg::OP_LOAD_B, 8'd7, 32'd3, '0, '0);
        issue(pjss_pkg::OP_LOAD_A, 8'd8, 32'd1, '0, '0);
        issue(pjss_pkg::OP_SCHED, '0, '0, 12'h555, 12'haaa);
        // Nothing buffered on either side.
        issue(pjss_pkg::OP_SCHED, '0, '0, 12'd3, 12'd4);
        // An odd job with job B empty, and the mirror case.
        issue(pjss_pkg::OP_LOAD_A, 8'd5, 32'd4, '0, '0);
        issue(pjss_pkg::OP_LOAD_A, 8'd200, 32'haaaa_5555, '0, '0);
        issue(pjss_pkg::OP_SCHED, '0, '0, 12'd9, 12'd10);
        issue(pjss_pkg::OP_LOAD_B, 8'd1, 32'h5555_aaaa, '0, '0);
        issue(pjss_pkg::OP_SCHED, '0, '0, 12'd11, 12'd12);
        issue(pjss_pkg::OP_REPORT, '0, '0, '0, '0);
        issue(OP_SPARE, '0, '0, '0, '0);
        issue(OP_SPARE + 3'd1, '0, '0, '0, '0);
        issue(OP_SPARE + 3'd2, '0, '0, '0, '0);
        issue(pjss_pkg::OP_CLEAR, '0, '0, '0, '0);
        issue(pjss_pkg::OP_REPORT, '0, '0, '0, '0);

        run_phase(0, PHASE_ITEMS, 1'b1);
        run_phase(77, PHASE_ITEMS, 1'b0);
        run_phase(0, PHASE_ITEMS, 1'b0);
        run_phase(31, PHASE_ITEMS, 1'b0);
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/pjss_pkg.sv
rtl/pjss_ram.sv
rtl/pjss_datapath.sv
rtl/pjss_ctrl.sv
rtl/pairwise_job_shop_scheduler.sv
test/tb_pairwise_job_shop_scheduler.sv
